@@ design/swfd_pkg.sv @@
// shared types and constants for the sync word frame deframer
package swfd_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [7:0]  TYPE_RANGES = 8'h01;
  localparam logic [15:0] TERMINATOR  = 16'h0D0A;
  localparam logic [31:0] REMAP_RESET = 32'h40800000;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DROP,
    S_STRIP,
    S_EMIT_FRAME,
    S_EMIT_TIMEOUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic append;
    logic shift;
    logic clear;
    logic load_frame;
    logic load_timeout;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic byte_keep;
    logic fill_last;
    logic fill_zero;
    logic head_sync;
    logic hdr_ok;
    logic term_ok;
    logic out_free;
  } status_t;

endpackage

@@ design/sync_word_frame_deframer_core.sv @@
// top level of the sync word frame deframer: controller plus datapath
// result load: a timeout beat loads the result register at its accepting edge when the
//   register is free; a good frame passes the check state, then loads in the emit state
// input: one byte beat per cycle while idle; a good frame stalls input through check and load,
//   a bad frame through drop, rescan one entry per cycle and exit; a held result adds more
// reset: rst_n synchronous active low, empties the buffer, drops any pending result,
//   remap word returns to 0x40800000 (4.0)
module sync_word_frame_deframer_core
  import swfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_tick_count,
  output logic [31:0] out_range_front_left,
  output logic [31:0] out_range_front_right,
  output logic [31:0] out_range_rear_right,
  output logic [31:0] out_range_rear_left,
  output logic [15:0] out_sonar_count,
  output logic        out_timed_out
);

  // command and status between the two halves
  cmd_t    cmd;
  status_t status;

  // state machine: takes beats while idle, checks a full buffer,
  // walks the shift-down rescan and waits on the result register
  swfd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // byte buffer held as a shift line, fixed-position field decode,
  // not-valid remap and the output register
  swfd_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .in_rx_byte            (in_rx_byte),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_tick_count        (out_tick_count),
    .out_range_front_left  (out_range_front_left),
    .out_range_front_right (out_range_front_right),
    .out_range_rear_right  (out_range_rear_right),
    .out_range_rear_left   (out_range_rear_left),
    .out_sonar_count       (out_sonar_count),
    .out_timed_out         (out_timed_out)
  );

endmodule

@@ design/swfd_ctrl.sv @@
// controller state machine for the sync word frame deframer
module swfd_ctrl
  import swfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_req_type,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic in_fire;
    in_fire   = in_valid && (state_r == S_IDLE);
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req_type == REQ_TIMEOUT) begin
            if (status.out_free) begin
              cmd.load_timeout = 1'b1;
            end else begin
              state_nxt = S_EMIT_TIMEOUT;
            end
          end else if (status.byte_keep) begin
            cmd.append = 1'b1;
            if (status.fill_last) begin
              state_nxt = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        if (!status.hdr_ok) begin
          cmd.shift = 1'b1;
          state_nxt = S_STRIP;
        end else if (!status.term_ok) begin
          cmd.shift = 1'b1;
          state_nxt = S_DROP;
        end else begin
          state_nxt = S_EMIT_FRAME;
        end
      end
      S_DROP: begin
        cmd.shift = 1'b1;
        state_nxt = S_STRIP;
      end
      S_STRIP: begin
        if (!status.fill_zero && !status.head_sync) begin
          cmd.shift = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_FRAME: begin
        if (status.out_free) begin
          cmd.load_frame = 1'b1;
          cmd.clear      = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_EMIT_TIMEOUT: begin
        if (status.out_free) begin
          cmd.load_timeout = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/swfd_datapath.sv @@
// byte buffer, field extraction and result register of the deframer
module swfd_datapath
  import swfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [7:0]  in_rx_byte,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_tick_count,
  output logic [31:0] out_range_front_left,
  output logic [31:0] out_range_front_right,
  output logic [31:0] out_range_rear_right,
  output logic [31:0] out_range_rear_left,
  output logic [15:0] out_sonar_count,
  output logic        out_timed_out
);

  logic [7:0]        buf_r [FRAME_BYTES];
  logic [FILL_W-1:0] fill_r;
  logic [31:0]       remap_r;
  logic              out_valid_r;
  logic [31:0]       tick_r, fl_r, fr_r, rr_r, rl_r;
  logic [15:0]       sonar_r;
  logic              timed_out_r;

  logic [31:0] bad_word;
  logic [31:0] range_word [4];
  logic [31:0] dist_fix [4];

  // byte buffer: append at fill level, shift down one entry to drop the head
  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (cmd.append && (fill_r[IDX_W-1:0] == IDX_W'(i))) begin
        buf_r[i] <= in_rx_byte;
      end else if (cmd.shift && (i < FRAME_BYTES - 1)) begin
        buf_r[i] <= buf_r[(i + 1) % FRAME_BYTES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.clear) begin
      fill_r <= '0;
    end else if (cmd.append) begin
      fill_r <= fill_r + FILL_W'(1);
    end else if (cmd.shift) begin
      fill_r <= fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_r <= REMAP_RESET;
    end else if (cfg_we) begin
      remap_r <= cfg_wdata;
    end
  end

  assign bad_word = {buf_r[11], buf_r[10], buf_r[9], buf_r[8]};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      range_word[k] = {buf_r[15 + 4 * k], buf_r[14 + 4 * k],
                       buf_r[13 + 4 * k], buf_r[12 + 4 * k]};
      dist_fix[k] = (range_word[k] == bad_word) ? remap_r : range_word[k];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_frame || cmd.load_timeout) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_timeout) begin
      tick_r      <= '0;
      fl_r        <= remap_r;
      fr_r        <= remap_r;
      rr_r        <= remap_r;
      rl_r        <= remap_r;
      sonar_r     <= '0;
      timed_out_r <= 1'b1;
    end else if (cmd.load_frame) begin
      tick_r      <= {buf_r[7], buf_r[6], buf_r[5], buf_r[4]};
      fl_r        <= dist_fix[0];
      fr_r        <= dist_fix[1];
      rr_r        <= dist_fix[2];
      rl_r        <= dist_fix[3];
      sonar_r     <= {buf_r[29], buf_r[28]};
      timed_out_r <= 1'b0;
    end
  end

  always_comb begin
    status.fill_zero = (fill_r == '0);
    status.byte_keep = (fill_r != '0) || (in_rx_byte == SYNC_FIRST);
    status.fill_last = (fill_r == FILL_W'(FRAME_BYTES - 1));
    status.head_sync = (buf_r[0] == SYNC_FIRST);
    status.hdr_ok    = (buf_r[1] == SYNC_SECOND) && (buf_r[3] == TYPE_RANGES);
    status.term_ok   = ({buf_r[FRAME_BYTES - 1], buf_r[FRAME_BYTES - 2]} == TERMINATOR);
    status.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid             = out_valid_r;
  assign out_tick_count        = tick_r;
  assign out_range_front_left  = fl_r;
  assign out_range_front_right = fr_r;
  assign out_range_rear_right  = rr_r;
  assign out_range_rear_left   = rl_r;
  assign out_sonar_count       = sonar_r;
  assign out_timed_out         = timed_out_r;

endmodule

@@ test/swfd_checker.sv @@
`timescale 1ns / 100ps
// watches both beat channels of the deframer, predicts each result and compares it
module swfd_checker
  import swfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_tick_count,
  input  logic [31:0] out_range_front_left,
  input  logic [31:0] out_range_front_right,
  input  logic [31:0] out_range_rear_right,
  input  logic [31:0] out_range_rear_left,
  input  logic [15:0] out_sonar_count,
  input  logic        out_timed_out,
  output int          fail_count,
  output int          results_due,
  output int          frames_seen,
  output int          timeouts_seen
);

  typedef struct packed {
    logic [31:0] tick_count;
    logic [31:0] front_left;
    logic [31:0] front_right;
    logic [31:0] rear_right;
    logic [31:0] rear_left;
    logic [15:0] sonar_count;
    logic        timed_out;
  } range_report_t;

  range_report_t reports_due[$];
  logic [7:0]    rx_window[FRAME_BYTES];
  int            rx_fill;
  logic [31:0]   remap_q;
  int            errors;
  int            n_frames;
  int            n_timeouts;

  function automatic void drop_bytes(input int count);
    if (count >= rx_fill) begin
      rx_fill = 0;
    end else begin
      for (int i = 0; i < rx_fill - count; i++) rx_window[i] = rx_window[i + count];
      rx_fill -= count;
    end
  endfunction

  function automatic void strip_leading_junk();
    while (rx_fill > 0 && rx_window[0] != SYNC_FIRST) drop_bytes(1);
  endfunction

  function automatic logic [31:0] window_le32(input int pos);
    return {rx_window[pos + 3], rx_window[pos + 2], rx_window[pos + 1], rx_window[pos]};
  endfunction

  function automatic logic [31:0] remapped(input logic [31:0] range_in,
                                           input logic [31:0] not_valid);
    return (range_in == not_valid) ? remap_q : range_in;
  endfunction

  function automatic void predict_timeout();
    range_report_t r;
    r.tick_count  = '0;
    r.front_left  = remap_q;
    r.front_right = remap_q;
    r.rear_right  = remap_q;
    r.rear_left   = remap_q;
    r.sonar_count = '0;
    r.timed_out   = 1'b1;
    reports_due.push_back(r);
  endfunction

  function automatic void predict_byte(input logic [7:0] data);
    range_report_t r;
    logic [31:0]   not_valid;
    if (rx_fill < FRAME_BYTES) begin
      rx_window[rx_fill] = data;
      rx_fill++;
    end
    strip_leading_junk();
    if (rx_fill == FRAME_BYTES) begin
      if (rx_window[1] != SYNC_SECOND || rx_window[3] != TYPE_RANGES) begin
        drop_bytes(1);
        strip_leading_junk();
      end else if ({rx_window[31], rx_window[30]} != TERMINATOR) begin
        drop_bytes(2);
        strip_leading_junk();
      end else begin
        not_valid     = window_le32(8);
        r.tick_count  = window_le32(4);
        r.front_left  = remapped(window_le32(12), not_valid);
        r.front_right = remapped(window_le32(16), not_valid);
        r.rear_right  = remapped(window_le32(20), not_valid);
        r.rear_left   = remapped(window_le32(24), not_valid);
        r.sonar_count = {rx_window[29], rx_window[28]};
        r.timed_out   = 1'b0;
        reports_due.push_back(r);
        rx_fill = 0;
      end
    end
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("%t: %s mismatch, expected %h got %h", $realtime, field, want, got);
    end
  endfunction

  function automatic void check_report();
    range_report_t want;
    if (reports_due.size() == 0) begin
      errors++;
      if (errors <= 10) $display("%t: result beat with nothing expected", $realtime);
    end else begin
      want = reports_due.pop_front();
      compare_field("tick_count", want.tick_count, out_tick_count);
      compare_field("range_front_left", want.front_left, out_range_front_left);
      compare_field("range_front_right", want.front_right, out_range_front_right);
      compare_field("range_rear_right", want.rear_right, out_range_rear_right);
      compare_field("range_rear_left", want.rear_left, out_range_rear_left);
      compare_field("sonar_count", {16'h0, want.sonar_count}, {16'h0, out_sonar_count});
      compare_field("timed_out", {31'h0, want.timed_out}, {31'h0, out_timed_out});
      if (want.timed_out) n_timeouts++;
      else n_frames++;
    end
  endfunction

  initial begin
    errors     = 0;
    n_frames   = 0;
    n_timeouts = 0;
    rx_fill    = 0;
    remap_q    = REMAP_RESET;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reports_due.delete();
      rx_fill = 0;
      remap_q = REMAP_RESET;
    end else begin
      if (cfg_we) remap_q = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_req_type == REQ_TIMEOUT) predict_timeout();
        else predict_byte(in_rx_byte);
      end
      if (out_valid && !out_stall) check_report();
    end
    fail_count    <= errors;
    results_due   <= reports_due.size();
    frames_seen   <= n_frames;
    timeouts_seen <= n_timeouts;
  end

endmodule

@@ test/sync_word_frame_deframer_core_tb.sv @@
`timescale 1ns / 100ps
// stimulus and verdict for the sync word frame deframer core
module sync_word_frame_deframer_core_tb;
  import swfd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_req_type;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_tick_count;
  logic [31:0] out_range_front_left;
  logic [31:0] out_range_front_right;
  logic [31:0] out_range_rear_right;
  logic [31:0] out_range_rear_left;
  logic [15:0] out_sonar_count;
  logic        out_timed_out;

  int fail_count;
  int results_due;
  int frames_seen;
  int timeouts_seen;

  // idle odds in percent per cycle, and a pending receiver hold-off in cycles
  int send_gap_pct;
  int stall_pct;
  int hold_cycles;
  int beats_sent;
  int remaps_written;

  // byte image of the frame about to go out
  logic [7:0] frame_img[FRAME_BYTES];

  sync_word_frame_deframer_core u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_tick_count        (out_tick_count),
    .out_range_front_left  (out_range_front_left),
    .out_range_front_right (out_range_front_right),
    .out_range_rear_right  (out_range_rear_right),
    .out_range_rear_left   (out_range_rear_left),
    .out_sonar_count       (out_sonar_count),
    .out_timed_out         (out_timed_out)
  );

  // predicts every result from the accepted beats and scores the result beats
  swfd_checker u_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_req_type           (in_req_type),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_tick_count        (out_tick_count),
    .out_range_front_left  (out_range_front_left),
    .out_range_front_right (out_range_front_right),
    .out_range_rear_right  (out_range_rear_right),
    .out_range_rear_left   (out_range_rear_left),
    .out_sonar_count       (out_sonar_count),
    .out_timed_out         (out_timed_out),
    .fail_count            (fail_count),
    .results_due           (results_due),
    .frames_seen           (frames_seen),
    .timeouts_seen         (timeouts_seen)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off counted down here when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #(5_000_000);
    $display("timeout with %0d results still expected", results_due);
    $display("FAILED: results differ");
    $finish;
  end

  // one input beat; called and returns at a falling edge, valid stays high between
  // back-to-back beats so it is never dropped and raised in the same step
  task automatic send_beat(input logic req, input logic [7:0] data);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_rx_byte  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  function automatic void put_le32(input int pos, input logic [31:0] value);
    for (int i = 0; i < 4; i++) frame_img[pos + i] = value[8*i +: 8];
  endfunction

  // well-formed frame with a random count byte
  function automatic void build_frame(input logic [31:0] ticks, input logic [31:0] not_valid,
                                      input logic [31:0] fl, input logic [31:0] fr,
                                      input logic [31:0] rr, input logic [31:0] rl,
                                      input logic [15:0] sonars);
    frame_img[0] = SYNC_FIRST;
    frame_img[1] = SYNC_SECOND;
    frame_img[2] = 8'($urandom_range(255));
    frame_img[3] = TYPE_RANGES;
    put_le32(4, ticks);
    put_le32(8, not_valid);
    put_le32(12, fl);
    put_le32(16, fr);
    put_le32(20, rr);
    put_le32(24, rl);
    frame_img[28] = sonars[7:0];
    frame_img[29] = sonars[15:8];
    frame_img[30] = TERMINATOR[7:0];
    frame_img[31] = TERMINATOR[15:8];
  endfunction

  // random frame where each distance has a one in three chance of carrying the
  // not-valid word
  function automatic void random_frame();
    logic [31:0] nv;
    logic [31:0] range_val[4];
    nv = $urandom;
    for (int k = 0; k < 4; k++) range_val[k] = ($urandom_range(2) == 0) ? nv : $urandom;
    build_frame($urandom, nv, range_val[0], range_val[1], range_val[2], range_val[3],
                16'($urandom_range(65535)));
  endfunction

  // first n_bytes of the image; a timeout beat slips in ahead of byte timeout_at
  task automatic send_frame(input int n_bytes, input int timeout_at);
    for (int i = 0; i < n_bytes; i++) begin
      if (i == timeout_at) send_beat(REQ_TIMEOUT, 8'($urandom_range(255)));
      send_beat(REQ_BYTE, frame_img[i]);
    end
  endtask

  // the remap word only changes with the block drained; the extra wait covers a
  // rescan of a bad frame that produces no result
  task automatic write_remap(input logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (48) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    remaps_written++;
  endtask

  // random traffic: mostly good frames, the rest broken frames, junk and timeouts
  task automatic run_phase(input int gap, input int stall, input int n_beats,
                           input logic with_hold);
    int target;
    int pick;
    int pos;
    send_gap_pct = gap;
    stall_pct    = stall;
    target       = beats_sent + n_beats;
    if (with_hold) begin
      // receiver freezes while frames keep coming, so the buffer fills and in_stall rises
      hold_cycles = 300;
      for (int f = 0; f < 4; f++) begin
        random_frame();
        send_frame(FRAME_BYTES, -1);
      end
    end
    while (beats_sent < target) begin
      pick = $urandom_range(99);
      random_frame();
      if (pick < 58) begin
        // good frame, sometimes with a timeout in the middle
        send_frame(FRAME_BYTES, ($urandom_range(7) == 0) ? $urandom_range(1, 31) : -1);
      end else if (pick < 66) begin
        // bad second sync byte
        frame_img[1] ^= 8'($urandom_range(1, 255));
        send_frame(FRAME_BYTES, -1);
      end else if (pick < 74) begin
        // bad type
        frame_img[3] ^= 8'($urandom_range(1, 255));
        send_frame(FRAME_BYTES, -1);
      end else if (pick < 82) begin
        // bad terminator, one or both bytes
        pos = 30 + $urandom_range(1);
        frame_img[pos] ^= 8'($urandom_range(1, 255));
        if ($urandom_range(3) == 0) frame_img[61 - pos] ^= 8'($urandom_range(1, 255));
        send_frame(FRAME_BYTES, -1);
      end else if (pick < 89) begin
        // noise bytes, with stray sync bytes mixed in
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(3))
            0:       send_beat(REQ_BYTE, SYNC_FIRST);
            1:       send_beat(REQ_BYTE, SYNC_SECOND);
            default: send_beat(REQ_BYTE, 8'($urandom_range(255)));
          endcase
        end
      end else if (pick < 95) begin
        send_beat(REQ_TIMEOUT, 8'($urandom_range(255)));
      end else begin
        // truncated frame, the next one will overlap it
        send_frame($urandom_range(1, 31), -1);
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_req_type    = REQ_BYTE;
    in_rx_byte     = '0;
    send_gap_pct   = 0;
    stall_pct      = 0;
    hold_cycles    = 0;
    beats_sent     = 0;
    remaps_written = 0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: timeout on an empty buffer shows the reset remap word
    send_beat(REQ_TIMEOUT, 8'hFF);
    // leading junk, including a lone second sync byte
    send_beat(REQ_BYTE, 8'h00);
    send_beat(REQ_BYTE, 8'hFF);
    send_beat(REQ_BYTE, SYNC_SECOND);
    // field extremes, two distances not valid
    build_frame(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0001, 16'hFFFF);
    send_frame(FRAME_BYTES, -1);
    // stray first sync byte ahead of a frame: bad second sync, one byte dropped
    build_frame(32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                16'h0);
    send_beat(REQ_BYTE, SYNC_FIRST);
    send_frame(FRAME_BYTES, -1);
    // bad type, then a good frame with a timeout after its first ten bytes
    random_frame();
    frame_img[3] = 8'h00;
    send_frame(FRAME_BYTES, -1);
    random_frame();
    send_frame(FRAME_BYTES, 10);
    // terminator bytes swapped, then a frame whose count byte is ignored
    random_frame();
    frame_img[30] = TERMINATOR[15:8];
    frame_img[31] = TERMINATOR[7:0];
    send_frame(FRAME_BYTES, -1);
    random_frame();
    send_frame(FRAME_BYTES, -1);

    // all four distances not valid under an all-ones remap word
    write_remap(32'hFFFF_FFFF);
    build_frame(32'h0000_0001, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF,
                32'hDEAD_BEEF, 16'h0001);
    send_frame(FRAME_BYTES, -1);
    send_beat(REQ_TIMEOUT, 8'h00);

    // sender idles 32%, receiver 63%
    write_remap(32'h0000_0000);
    run_phase(32, 63, 590, 1'b0);
    // sender idles 63%, receiver 32%
    write_remap($urandom);
    run_phase(63, 32, 590, 1'b0);
    // no idling, with one long receiver hold-off at the start
    write_remap(REMAP_RESET);
    run_phase(0, 0, 590, 1'b1);

    // drain: wait for every expected result, then a settling margin
    in_valid  <= 1'b0;
    stall_pct  = 0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("sent %0d input beats under 3 idle patterns and %0d remap settings",
             beats_sent, remaps_written + 1);
    $display("checked %0d frame results and %0d timeout results, %0d mismatches",
             frames_seen, timeouts_seen, fail_count);
    if (fail_count == 0 && results_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/swfd_pkg.sv
design/swfd_ctrl.sv
design/swfd_datapath.sv
design/sync_word_frame_deframer_core.sv
test/swfd_checker.sv
test/sync_word_frame_deframer_core_tb.sv
